@@ rtl/core/sfa_pkg.sv @@
// Package with types, constants and helper functions of the binary32 ALU.
`default_nettype none

package sfa_pkg;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 104;

    // Binary32 and int64 bit patterns.
    localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS     = 32'h7F80_0000;
    localparam logic [31:0] MAG_MASK     = 32'h7FFF_FFFF;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
    localparam logic [63:0] INT_MIN_BITS = 64'h8000_0000_0000_0000;

    // Quotient bits produced by the divider after its first partial remainder.
    localparam logic [5:0] DIV_LAST_STEP = 6'd40;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_LESS     = 4'd4,
        OP_EQUAL    = 4'd5,
        OP_NEGATE   = 4'd6,
        OP_TO_INT   = 4'd7,
        OP_FROM_INT = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALIGN,
        ST_DIVIDE,
        ST_NORM,
        ST_ROUND,
        ST_TOINT,
        ST_FINISH
    } t_state;

    // Request to and response from the shared shifter.
    typedef struct packed {
        logic [63:0] value;
        logic [7:0]  amount;
        logic        left;
    } t_shift_req;

    typedef struct packed {
        logic [63:0] value;
        logic        sticky;
    } t_shift_rsp;

    function automatic logic is_nan(input logic [31:0] x);
        return (x & MAG_MASK) > INF_BITS;
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (x & MAG_MASK) == INF_BITS;
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return (x & MAG_MASK) == 32'd0;
    endfunction

    // Significand with the hidden bit for normal numbers.
    function automatic logic [23:0] unpack_sig(input logic [31:0] x);
        return {(x[30:23] != 8'd0), x[22:0]};
    endfunction

    // Exponent of the significand's lowest bit.
    function automatic logic signed [11:0] unpack_exp(input logic [31:0] x);
        if (x[30:23] == 8'd0) begin
            return -12'sd149;
        end
        return $signed({4'b0, x[30:23]}) - 12'sd150;
    endfunction

    // Leading zeros of a nonzero 24-bit value.
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sfa_shift.sv @@
// Shared 64-bit shifter with a sticky bit for the bits lost on a right shift.
`default_nettype none

module sfa_shift
    import sfa_pkg::*;
(
    input  t_shift_req i_req,
    output t_shift_rsp o_rsp
);

    logic [5:0]  shamt;
    logic [63:0] lost_mask;

    assign shamt     = i_req.amount[5:0];
    assign lost_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << shamt);

    // Amounts of 64 and more move every bit out.
    always_comb begin
        if (i_req.amount >= 8'd64) begin
            o_rsp.value  = 64'd0;
            o_rsp.sticky = !i_req.left && (i_req.value != 64'd0);
        end else if (i_req.left) begin
            o_rsp.value  = i_req.value << shamt;
            o_rsp.sticky = 1'b0;
        end else begin
            o_rsp.value  = i_req.value >> shamt;
            o_rsp.sticky = (i_req.value & lost_mask) != 64'd0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/single_precision_float_alu.sv @@
// Top level of the iterative binary32 ALU: sequencer, datapath and output register.
//
//  channel   | direction | tdata fields (lowest bit up)                          | tuser
//  s_axis    | in        | opcode[3:0] operand_a[35:4] operand_b[67:36]          | none
//            |           | int_operand[131:68], zero pad to 136                  |
//  m_axis    | out       | float_result[31:0] int_result[95:32] compare_flag[96] | none
//            |           | zero pad to 104                                       |
//
// One beat is in flight at a time; tready is high only while the sequencer is idle.
// Compares, negate and special operands go from decode straight to finish; a cancelling
// subtract finishes after align, to_int after its shift, add and subtract after align,
// normalize and round, multiply and from_int after normalize and round, and divide after
// 41 quotient bits, normalize and round. A full output register holds the sequencer.
// Reset is synchronous and active low and clears the sequencer and output valid.
`default_nettype none

module single_precision_float_alu
    import sfa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // opcode, operand_a, operand_b, int_operand, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // float_result, int_result, compare_flag, zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    t_state r_state, n_state;

    logic [3:0]  r_op, n_op;
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [63:0] r_int, n_int;

    logic               r_sign, n_sign;
    logic signed [11:0] r_exp, n_exp;
    logic [63:0]        r_sig, n_sig;
    logic [63:0]        r_mb, n_mb;
    logic               r_stk, n_stk;
    logic               r_sub, n_sub;
    logic [7:0]         r_dist, n_dist;
    logic [23:0]        r_rem, n_rem;
    logic               r_lowbit, n_lowbit;
    logic [5:0]         r_cnt, n_cnt;

    logic [31:0] r_fres, n_fres;
    logic [63:0] r_ires, n_ires;
    logic        r_cflag, n_cflag;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    t_shift_req shift_req;
    t_shift_rsp shift_rsp;

    logic in_beat;
    logic out_beat;

    // Shared shifter.
    sfa_shift u_shift (
        .i_req (shift_req),
        .o_rsp (shift_rsp)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat        = r_out_valid && i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Operand decode shared by the operations.
    logic [31:0]        b_eff;
    logic [31:0]        big_op, small_op;
    logic [23:0]        ma, mb, mx, my;
    logic signed [11:0] ea, eb, ex, ey, d_xy;
    logic [4:0]         lza, lzb;
    logic [23:0]        na, nb;
    logic [47:0]        product;
    logic               fp_eq, fp_lt;
    logic [63:0]        int_mag;

    always_comb begin
        b_eff = (r_op == OP_SUB && !is_nan(r_b)) ? (r_b ^ SIGN_BIT) : r_b;
        if ((r_a & MAG_MASK) < (b_eff & MAG_MASK)) begin
            big_op   = b_eff;
            small_op = r_a;
        end else begin
            big_op   = r_a;
            small_op = b_eff;
        end
        ma      = unpack_sig(r_a);
        mb      = unpack_sig(b_eff);
        ea      = unpack_exp(r_a);
        eb      = unpack_exp(b_eff);
        mx      = unpack_sig(big_op);
        my      = unpack_sig(small_op);
        ex      = unpack_exp(big_op);
        ey      = unpack_exp(small_op);
        d_xy    = ex - ey;
        lza     = lzc24(ma);
        lzb     = lzc24(mb);
        na      = ma << lza;
        nb      = mb << lzb;
        product = ma * mb;
        fp_eq   = !is_nan(r_a) && !is_nan(r_b)
                  && ((is_zero(r_a) && is_zero(r_b)) || (r_a == r_b));
        if (is_nan(r_a) || is_nan(r_b) || fp_eq) begin
            fp_lt = 1'b0;
        end else if (r_a[31] != r_b[31]) begin
            fp_lt = r_a[31];
        end else begin
            fp_lt = r_a[31] ? (r_a > r_b) : (r_a < r_b);
        end
        int_mag = r_int[63] ? (64'd0 - r_int) : r_int;
    end

    // Normalize step: the largest power-of-two shift that keeps the top bit in place.
    logic [7:0] norm_amt;

    always_comb begin
        if (r_sig[63:32] == 32'd0) begin
            norm_amt = 8'd32;
        end else if (r_sig[63:48] == 16'd0) begin
            norm_amt = 8'd16;
        end else if (r_sig[63:56] == 8'd0) begin
            norm_amt = 8'd8;
        end else if (r_sig[63:60] == 4'd0) begin
            norm_amt = 8'd4;
        end else if (r_sig[63:62] == 2'd0) begin
            norm_amt = 8'd2;
        end else begin
            norm_amt = 8'd1;
        end
    end

    // Rounding: exponent of the top bit and the denormalizing shift.
    logic signed [11:0] big_e, dd, qm, expf;
    logic               big_ge;
    logic [7:0]         den_amt;
    logic [23:0]        kept, kept2;
    logic [24:0]        kept1;
    logic               rnd, stk_all, carry;

    always_comb begin
        big_e   = r_exp + 12'sd63;
        big_ge  = big_e >= -12'sd126;
        dd      = -12'sd126 - big_e;
        den_amt = big_ge ? 8'd0 : ((dd > 12'sd255) ? 8'hFF : dd[7:0]);
        qm      = big_ge ? big_e : -12'sd126;
        kept    = shift_rsp.value[63:40];
        rnd     = shift_rsp.value[39];
        stk_all = r_stk || shift_rsp.sticky || (shift_rsp.value[38:0] != 39'd0);
        kept1   = {1'b0, kept} + {24'd0, rnd && (stk_all || kept[0])};
        carry   = kept1[24];
        kept2   = carry ? kept1[24:1] : kept1[23:0];
        expf    = qm + 12'sd127 + $signed({11'b0, carry});
    end

    // Conversion to integer.
    logic [4:0]         int_top;
    logic signed [11:0] int_reach;
    logic signed [11:0] neg_exp;

    always_comb begin
        int_top   = 5'd23 - lzc24(r_sig[23:0]);
        int_reach = $signed({7'b0, int_top}) + r_exp;
        neg_exp   = -r_exp;
    end

    // Divider step: one restoring subtract per cycle.
    logic [24:0] trial, rem_next;
    logic        qbit;

    always_comb begin
        trial    = {r_rem, (r_cnt == DIV_LAST_STEP) ? r_lowbit : 1'b0};
        qbit     = trial >= {1'b0, r_mb[23:0]};
        rem_next = qbit ? (trial - {1'b0, r_mb[23:0]}) : trial;
    end

    // Shifter operands by state.
    always_comb begin
        shift_req.value  = r_sig;
        shift_req.amount = 8'd0;
        shift_req.left   = 1'b0;
        case (r_state)
            ST_ALIGN: begin
                shift_req.value  = r_mb;
                shift_req.amount = r_dist;
            end
            ST_NORM: begin
                shift_req.amount = norm_amt;
                shift_req.left   = 1'b1;
            end
            ST_ROUND: begin
                shift_req.amount = den_amt;
            end
            ST_TOINT: begin
                shift_req.left   = !r_exp[11];
                shift_req.amount = r_exp[11] ? neg_exp[7:0] : r_exp[7:0];
            end
            default: begin
                shift_req.amount = 8'd0;
            end
        endcase
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_int       = r_int;
        n_sign      = r_sign;
        n_exp       = r_exp;
        n_sig       = r_sig;
        n_mb        = r_mb;
        n_stk       = r_stk;
        n_sub       = r_sub;
        n_dist      = r_dist;
        n_rem       = r_rem;
        n_lowbit    = r_lowbit;
        n_cnt       = r_cnt;
        n_fres      = r_fres;
        n_ires      = r_ires;
        n_cflag     = r_cflag;
        n_out_valid = r_out_valid && !out_beat;
        n_out_data  = r_out_data;

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_op    = i_s_axis_tdata[3:0];
                    n_a     = i_s_axis_tdata[35:4];
                    n_b     = i_s_axis_tdata[67:36];
                    n_int   = i_s_axis_tdata[131:68];
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_fres  = 32'd0;
                n_ires  = 64'd0;
                n_cflag = 1'b0;
                n_stk   = 1'b0;
                n_state = ST_FINISH;
                case (t_opcode'(r_op))
                    OP_ADD, OP_SUB: begin
                        if (is_nan(r_a) || is_nan(b_eff)) begin
                            n_fres = QNAN_BITS;
                        end else if (is_inf(r_a) && is_inf(b_eff)) begin
                            n_fres = (r_a[31] ^ b_eff[31]) ? QNAN_BITS : r_a;
                        end else if (is_inf(r_a)) begin
                            n_fres = r_a;
                        end else if (is_inf(b_eff)) begin
                            n_fres = b_eff;
                        end else if (is_zero(r_a) && is_zero(b_eff)) begin
                            n_fres = r_a & b_eff & SIGN_BIT;
                        end else if (is_zero(r_a)) begin
                            n_fres = b_eff;
                        end else if (is_zero(b_eff)) begin
                            n_fres = r_a;
                        end else begin
                            n_sig   = {1'b0, mx, 39'd0};
                            n_mb    = {1'b0, my, 39'd0};
                            n_exp   = ex - 12'sd39;
                            n_dist  = d_xy[7:0];
                            n_sign  = big_op[31];
                            n_sub   = big_op[31] ^ small_op[31];
                            n_state = ST_ALIGN;
                        end
                    end
                    OP_MUL: begin
                        if (is_nan(r_a) || is_nan(b_eff)) begin
                            n_fres = QNAN_BITS;
                        end else if (is_inf(r_a) || is_inf(b_eff)) begin
                            n_fres = (is_zero(r_a) || is_zero(b_eff)) ? QNAN_BITS
                                   : ({r_a[31] ^ b_eff[31], 31'd0} | INF_BITS);
                        end else if (is_zero(r_a) || is_zero(b_eff)) begin
                            n_fres = {r_a[31] ^ b_eff[31], 31'd0};
                        end else begin
                            n_sig   = {16'd0, product};
                            n_exp   = ea + eb;
                            n_sign  = r_a[31] ^ b_eff[31];
                            n_state = ST_NORM;
                        end
                    end
                    OP_DIV: begin
                        if (is_nan(r_a) || is_nan(b_eff)) begin
                            n_fres = QNAN_BITS;
                        end else if ((is_inf(r_a) && is_inf(b_eff))
                                     || (is_zero(r_a) && is_zero(b_eff))) begin
                            n_fres = QNAN_BITS;
                        end else if (is_inf(r_a) || is_zero(b_eff)) begin
                            n_fres = {r_a[31] ^ b_eff[31], 31'd0} | INF_BITS;
                        end else if (is_zero(r_a) || is_inf(b_eff)) begin
                            n_fres = {r_a[31] ^ b_eff[31], 31'd0};
                        end else begin
                            n_rem    = {1'b0, na[23:1]};
                            n_lowbit = na[0];
                            n_mb     = {40'd0, nb};
                            n_sig    = 64'd0;
                            n_cnt    = DIV_LAST_STEP;
                            n_exp    = (ea - $signed({7'b0, lza})) - 12'sd40
                                       - (eb - $signed({7'b0, lzb}));
                            n_sign   = r_a[31] ^ b_eff[31];
                            n_state  = ST_DIVIDE;
                        end
                    end
                    OP_LESS: begin
                        n_cflag = fp_lt;
                    end
                    OP_EQUAL: begin
                        n_cflag = fp_eq;
                    end
                    OP_NEGATE: begin
                        n_fres = is_nan(r_a) ? r_a : (r_a ^ SIGN_BIT);
                    end
                    OP_TO_INT: begin
                        if (is_nan(r_a) || is_inf(r_a)) begin
                            n_ires = INT_MIN_BITS;
                        end else if (!is_zero(r_a)) begin
                            n_sig   = {40'd0, ma};
                            n_exp   = ea;
                            n_sign  = r_a[31];
                            n_state = ST_TOINT;
                        end
                    end
                    OP_FROM_INT: begin
                        n_sig   = int_mag;
                        n_exp   = 12'sd0;
                        n_sign  = r_int[63];
                        n_state = ST_NORM;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end

            // Align the smaller addend, then add or subtract with its sticky bit.
            ST_ALIGN: begin
                n_stk   = shift_rsp.sticky;
                n_state = ST_NORM;
                if (!r_sub) begin
                    n_sig = r_sig + shift_rsp.value;
                end else if (r_sig == shift_rsp.value && !shift_rsp.sticky) begin
                    n_fres  = 32'd0;
                    n_state = ST_FINISH;
                end else begin
                    n_sig = r_sig - shift_rsp.value - {63'd0, shift_rsp.sticky};
                end
            end

            ST_DIVIDE: begin
                n_rem = rem_next[23:0];
                n_sig = {r_sig[62:0], qbit};
                if (r_cnt == 6'd0) begin
                    n_stk   = rem_next != 25'd0;
                    n_state = ST_NORM;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end

            // Move the leading one to the top bit.
            ST_NORM: begin
                if (r_sig == 64'd0 || r_sig[63]) begin
                    n_state = ST_ROUND;
                end else begin
                    n_sig = shift_rsp.value;
                    n_exp = r_exp - $signed({4'b0, norm_amt});
                end
            end

            ST_ROUND: begin
                n_state = ST_FINISH;
                if (r_sig == 64'd0) begin
                    n_fres = {r_sign, 31'd0};
                end else if (!kept2[23]) begin
                    n_fres = {r_sign, 8'd0, kept2[22:0]};
                end else if (expf > 12'sd254) begin
                    n_fres = {r_sign, 31'd0} | INF_BITS;
                end else begin
                    n_fres = {r_sign, expf[7:0], kept2[22:0]};
                end
            end

            ST_TOINT: begin
                n_state = ST_FINISH;
                if (!r_exp[11] && int_reach >= 12'sd63) begin
                    n_ires = INT_MIN_BITS;
                end else begin
                    n_ires = r_sign ? (64'd0 - shift_rsp.value) : shift_rsp.value;
                end
            end

            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_cflag, r_ires, r_fres};
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_a        <= n_a;
        r_b        <= n_b;
        r_int      <= n_int;
        r_sign     <= n_sign;
        r_exp      <= n_exp;
        r_sig      <= n_sig;
        r_mb       <= n_mb;
        r_stk      <= n_stk;
        r_sub      <= n_sub;
        r_dist     <= n_dist;
        r_rem      <= n_rem;
        r_lowbit   <= n_lowbit;
        r_cnt      <= n_cnt;
        r_fres     <= n_fres;
        r_ires     <= n_ires;
        r_cflag    <= n_cflag;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

@@ rtl/core/sfa_checker.sv @@
// Port-level checks of the binary32 ALU, bound to the top level.
`default_nettype none

module sfa_checker
    import sfa_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Reset empties the output register.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Only one beat is worked on at a time.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while busy");

    // A compare result carries no float or integer result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[96]) |-> (o_m_axis_tdata[95:0] == 96'd0))
        else $error("compare beat with nonzero result fields");

    // A stalled output beat is held.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output beat dropped");

endmodule

bind single_precision_float_alu sfa_checker u_sfa_checker (.*);

`default_nettype wire
